/* rtl/core/prrts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prrts_pkg
// Shared types, codes and default sizes of the priority round-robin scheduler.
// ----------------------------------------------------------------------------
package prrts_pkg;

   localparam int DEF_NUM_TASKS      = 16;
   localparam int DEF_NUM_PRIORITIES = 8;

   localparam logic [1:0] KIND_CREATE   = 2'd0;
   localparam logic [1:0] KIND_DELAY    = 2'd1;
   localparam logic [1:0] KIND_TICK     = 2'd2;
   localparam logic [1:0] KIND_SCHEDULE = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_NO_RUN   = 2'd2;
   localparam logic [1:0] STATUS_NO_READY = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  task_priority;
      logic        yield_flag;
      logic [31:0] delay_ticks;
   } req_type;

   typedef struct packed {
      logic [3:0] task_id;
      logic       task_valid;
      logic [1:0] status;
      logic [4:0] woken_count;
   } rsp_type;

endpackage
`default_nettype wire

/* rtl/core/prrts_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prrts_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module prrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

/* rtl/core/priority_round_robin_task_scheduler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// priority_round_robin_task_scheduler
// Hardware task scheduler: per-priority FIFO ready queues and one delay queue,
// linked lists kept in RAM, walked by a sequencer.
// ----------------------------------------------------------------------------
// Create appends the new task to the tail of its priority queue; delay moves
// the running task from its ready queue to the tail of the delay queue; tick
// counts down every delayed task and moves each one that reaches zero to its
// ready queue; schedule takes the highest non-empty queue and rotates it when
// the running task heads it. Next command accepted at the result edge: busy covers all.
// Reset clears queue pointers, running task and task count; task RAMs unset.
// ----------------------------------------------------------------------------
module priority_round_robin_task_scheduler #(
   parameter int NUM_TASKS      = prrts_pkg::DEF_NUM_TASKS,
   parameter int NUM_PRIORITIES = prrts_pkg::DEF_NUM_PRIORITIES
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire prrts_pkg::req_type req_data,
   output logic                    rsp_valid,
   output prrts_pkg::rsp_type      rsp_data
);

   localparam int TW = $clog2(NUM_TASKS + 1);
   localparam int AW = $clog2(NUM_TASKS);
   localparam int PW = NUM_PRIORITIES > 1 ? $clog2(NUM_PRIORITIES) : 1;
   localparam int DW = PW + 33;
   localparam logic [TW-1:0] NIL = TW'(NUM_TASKS);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_CR      = 5'd1;
   localparam logic [4:0] S_CR2     = 5'd2;
   localparam logic [4:0] S_DL_RD   = 5'd3;
   localparam logic [4:0] S_DL_WR   = 5'd4;
   localparam logic [4:0] S_DL_HD   = 5'd5;
   localparam logic [4:0] S_DL_WALK = 5'd6;
   localparam logic [4:0] S_DL_CHK  = 5'd7;
   localparam logic [4:0] S_DL_AP   = 5'd8;
   localparam logic [4:0] S_DL_AP2  = 5'd9;
   localparam logic [4:0] S_TK_RD   = 5'd10;
   localparam logic [4:0] S_TK_EV   = 5'd11;
   localparam logic [4:0] S_TK_AP   = 5'd12;
   localparam logic [4:0] S_TK_AP2  = 5'd13;
   localparam logic [4:0] S_SC      = 5'd14;
   localparam logic [4:0] S_SC2     = 5'd15;
   localparam logic [4:0] S_RRD     = 5'd16;
   localparam logic [4:0] S_RW1     = 5'd17;
   localparam logic [4:0] S_RW2     = 5'd18;

   logic [4:0]         state_ff, state_in;
   prrts_pkg::req_type req_ff, req_in;
   logic [PW-1:0]      qsel_ff, qsel_in;
   logic [TW-1:0]      running_ff, running_in;
   logic [TW-1:0]      made_ff, made_in;
   logic [TW-1:0]      cur_ff, cur_in;
   logic [TW-1:0]      prev_ff, prev_in;
   logic [TW-1:0]      nx_ff, nx_in;
   logic [TW-1:0]      h_ff, h_in;
   logic [TW-1:0]      dhead_ff, dhead_in;
   logic [TW-1:0]      dtail_ff, dtail_in;
   logic [TW-1:0]      woken_ff, woken_in;
   logic               first_ff, first_in;
   logic               last_ff, last_in;
   prrts_pkg::rsp_type rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [TW-1:0] head_ff [NUM_PRIORITIES];
   logic [TW-1:0] tail_ff [NUM_PRIORITIES];
   logic          head_we, tail_we;
   logic [TW-1:0] head_in, tail_in;
   logic [TW-1:0] h_cur, t_cur;

   logic          d_we;
   logic [AW-1:0] d_waddr, d_raddr;
   logic [DW-1:0] d_wdata, d_rdata;
   logic          l_we;
   logic [AW-1:0] l_waddr, l_raddr;
   logic [TW-1:0] l_wdata, l_rdata;

   logic          enc_found;
   logic [PW-1:0] enc_sel;
   logic [PW-1:0] sat_prio;
   logic [31:0]   new_delay;

   prrts_ram #(.WIDTH(DW), .DEPTH(NUM_TASKS)) u_data_ram (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_waddr),
      .wr_data (d_wdata),
      .rd_addr (d_raddr),
      .rd_data (d_rdata)
   );

   prrts_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_link_ram (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (l_waddr),
      .wr_data (l_wdata),
      .rd_addr (l_raddr),
      .rd_data (l_rdata)
   );

   function automatic prrts_pkg::rsp_type mk_rsp(input logic [TW-1:0] id, input logic v,
                                                 input logic [1:0] st,
                                                 input logic [TW-1:0] w);
      prrts_pkg::rsp_type r;
      r.task_id     = 4'(id);
      r.task_valid  = v;
      r.status      = st;
      r.woken_count = 5'(w);
      return r;
   endfunction

   assign h_cur     = head_ff[qsel_ff];
   assign t_cur     = tail_ff[qsel_ff];
   assign new_delay = (d_rdata[31:0] != 32'd0) ? d_rdata[31:0] - 32'd1 : 32'd0;

   always_comb begin
      enc_found = 1'b0;
      enc_sel   = '0;
      for (int q = 0; q < NUM_PRIORITIES; q++) begin
         if (head_ff[q] != NIL) begin
            enc_found = 1'b1;
            enc_sel   = PW'(q);
         end
      end
   end

   always_comb begin
      if (int'(req_data.task_priority) >= NUM_PRIORITIES) begin
         sat_prio = PW'(NUM_PRIORITIES - 1);
      end else begin
         sat_prio = PW'(req_data.task_priority);
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      qsel_in      = qsel_ff;
      running_in   = running_ff;
      made_in      = made_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      nx_in        = nx_ff;
      h_in         = h_ff;
      dhead_in     = dhead_ff;
      dtail_in     = dtail_ff;
      woken_in     = woken_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      head_we      = 1'b0;
      head_in      = NIL;
      tail_we      = 1'b0;
      tail_in      = NIL;
      d_we         = 1'b0;
      d_waddr      = '0;
      d_wdata      = '0;
      d_raddr      = '0;
      l_we         = 1'b0;
      l_waddr      = '0;
      l_wdata      = NIL;
      l_raddr      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               qsel_in  = sat_prio;
               woken_in = '0;
               case (req_data.kind)
                  prrts_pkg::KIND_CREATE: state_in = S_CR;
                  prrts_pkg::KIND_DELAY:  state_in = S_DL_RD;
                  prrts_pkg::KIND_TICK: begin
                     cur_in   = dhead_ff;
                     prev_in  = NIL;
                     state_in = S_TK_RD;
                  end
                  default: state_in = S_SC;
               endcase
            end
         end
         S_CR: begin
            if (made_ff == NIL) begin
               rsp_in       = mk_rsp('0, 1'b0, prrts_pkg::STATUS_FULL, '0);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               d_we    = 1'b1;
               d_waddr = made_ff[AW-1:0];
               d_wdata = {qsel_ff, req_ff.yield_flag, 32'd0};
               l_we    = 1'b1;
               l_waddr = made_ff[AW-1:0];
               l_wdata = NIL;
               made_in = TW'(made_ff + 1'b1);
               cur_in  = made_ff;
               if (h_cur == NIL) begin
                  head_we      = 1'b1;
                  head_in      = made_ff;
                  tail_we      = 1'b1;
                  tail_in      = made_ff;
                  rsp_in       = mk_rsp(made_ff, 1'b1, prrts_pkg::STATUS_OK, '0);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_CR2;
               end
            end
         end
         S_CR2: begin
            l_we         = 1'b1;
            l_waddr      = t_cur[AW-1:0];
            l_wdata      = cur_ff;
            tail_we      = 1'b1;
            tail_in      = cur_ff;
            rsp_in       = mk_rsp(cur_ff, 1'b1, prrts_pkg::STATUS_OK, '0);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_DL_RD: begin
            if (running_ff == NIL) begin
               rsp_in       = mk_rsp('0, 1'b0, prrts_pkg::STATUS_NO_RUN, '0);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               d_raddr  = running_ff[AW-1:0];
               state_in = S_DL_WR;
            end
         end
         S_DL_WR: begin
            d_we     = 1'b1;
            d_waddr  = running_ff[AW-1:0];
            d_wdata  = {d_rdata[DW-1:32], req_ff.delay_ticks};
            qsel_in  = d_rdata[DW-1:33];
            state_in = S_DL_HD;
         end
         S_DL_HD: begin
            cur_in   = h_cur;
            prev_in  = NIL;
            state_in = S_DL_WALK;
         end
         S_DL_WALK: begin
            if (cur_ff == NIL) begin
               rsp_in       = mk_rsp(running_ff, 1'b1, prrts_pkg::STATUS_OK, '0);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               l_raddr  = cur_ff[AW-1:0];
               state_in = S_DL_CHK;
            end
         end
         S_DL_CHK: begin
            if (cur_ff == running_ff) begin
               if (prev_ff != NIL) begin
                  l_we    = 1'b1;
                  l_waddr = prev_ff[AW-1:0];
                  l_wdata = l_rdata;
               end else begin
                  head_we = 1'b1;
                  head_in = l_rdata;
               end
               if (t_cur == cur_ff) begin
                  tail_we = 1'b1;
                  tail_in = prev_ff;
               end
               state_in = S_DL_AP;
            end else begin
               prev_in  = cur_ff;
               cur_in   = l_rdata;
               state_in = S_DL_WALK;
            end
         end
         S_DL_AP: begin
            l_we    = 1'b1;
            l_waddr = running_ff[AW-1:0];
            l_wdata = NIL;
            if (dhead_ff == NIL) begin
               dhead_in     = running_ff;
               dtail_in     = running_ff;
               rsp_in       = mk_rsp(running_ff, 1'b1, prrts_pkg::STATUS_OK, '0);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_DL_AP2;
            end
         end
         S_DL_AP2: begin
            l_we         = 1'b1;
            l_waddr      = dtail_ff[AW-1:0];
            l_wdata      = running_ff;
            dtail_in     = running_ff;
            rsp_in       = mk_rsp(running_ff, 1'b1, prrts_pkg::STATUS_OK, '0);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_TK_RD: begin
            if (cur_ff == NIL) begin
               rsp_in       = mk_rsp('0, 1'b0, prrts_pkg::STATUS_OK, woken_ff);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               l_raddr  = cur_ff[AW-1:0];
               d_raddr  = cur_ff[AW-1:0];
               state_in = S_TK_EV;
            end
         end
         S_TK_EV: begin
            nx_in   = l_rdata;
            d_we    = 1'b1;
            d_waddr = cur_ff[AW-1:0];
            d_wdata = {d_rdata[DW-1:32], new_delay};
            if (new_delay == 32'd0) begin
               woken_in = TW'(woken_ff + 1'b1);
               if (prev_ff != NIL) begin
                  l_we    = 1'b1;
                  l_waddr = prev_ff[AW-1:0];
                  l_wdata = l_rdata;
               end else begin
                  dhead_in = l_rdata;
               end
               if (dtail_ff == cur_ff) begin
                  dtail_in = prev_ff;
               end
               qsel_in  = d_rdata[DW-1:33];
               state_in = S_TK_AP;
            end else begin
               prev_in  = cur_ff;
               cur_in   = l_rdata;
               state_in = S_TK_RD;
            end
         end
         S_TK_AP: begin
            l_we    = 1'b1;
            l_waddr = cur_ff[AW-1:0];
            l_wdata = NIL;
            if (h_cur == NIL) begin
               head_we  = 1'b1;
               head_in  = cur_ff;
               tail_we  = 1'b1;
               tail_in  = cur_ff;
               cur_in   = nx_ff;
               state_in = S_TK_RD;
            end else begin
               state_in = S_TK_AP2;
            end
         end
         S_TK_AP2: begin
            l_we     = 1'b1;
            l_waddr  = t_cur[AW-1:0];
            l_wdata  = cur_ff;
            tail_we  = 1'b1;
            tail_in  = cur_ff;
            cur_in   = nx_ff;
            state_in = S_TK_RD;
         end
         S_SC: begin
            if (!enc_found) begin
               rsp_in       = mk_rsp('0, 1'b0, prrts_pkg::STATUS_NO_READY, '0);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               qsel_in  = enc_sel;
               state_in = S_SC2;
            end
         end
         S_SC2: begin
            if (running_ff != NIL && running_ff == h_cur) begin
               l_raddr  = h_cur[AW-1:0];
               first_in = 1'b1;
               last_in  = 1'b0;
               state_in = S_RW1;
            end else begin
               running_in   = h_cur;
               rsp_in       = mk_rsp(h_cur, 1'b1, prrts_pkg::STATUS_OK, '0);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RRD: begin
            l_raddr  = h_cur[AW-1:0];
            state_in = S_RW1;
         end
         S_RW1: begin
            if (first_ff && l_rdata == NIL) begin
               running_in   = h_cur;
               rsp_in       = mk_rsp(h_cur, 1'b1, prrts_pkg::STATUS_OK, '0);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               l_we     = 1'b1;
               l_waddr  = t_cur[AW-1:0];
               l_wdata  = h_cur;
               tail_we  = 1'b1;
               tail_in  = h_cur;
               head_we  = 1'b1;
               head_in  = l_rdata;
               h_in     = h_cur;
               d_raddr  = l_rdata[AW-1:0];
               first_in = 1'b0;
               state_in = S_RW2;
            end
         end
         S_RW2: begin
            l_we    = 1'b1;
            l_waddr = h_ff[AW-1:0];
            l_wdata = NIL;
            if (last_ff || !d_rdata[32]) begin
               running_in   = h_cur;
               rsp_in       = mk_rsp(h_cur, 1'b1, prrts_pkg::STATUS_OK, '0);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               if (h_cur == running_ff) begin
                  last_in = 1'b1;
               end
               state_in = S_RRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         running_ff   <= NIL;
         made_ff      <= '0;
         dhead_ff     <= NIL;
         dtail_ff     <= NIL;
         rsp_valid_ff <= 1'b0;
         for (int q = 0; q < NUM_PRIORITIES; q++) begin
            head_ff[q] <= NIL;
            tail_ff[q] <= NIL;
         end
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         made_ff      <= made_in;
         dhead_ff     <= dhead_in;
         dtail_ff     <= dtail_in;
         rsp_valid_ff <= rsp_valid_in;
         if (head_we) begin
            head_ff[qsel_ff] <= head_in;
         end
         if (tail_we) begin
            tail_ff[qsel_ff] <= tail_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      qsel_ff  <= qsel_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      nx_ff    <= nx_in;
      h_ff     <= h_in;
      woken_ff <= woken_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result transfer while sequencer active");

   a_made_range: assert property (@(posedge clock) disable iff (reset)
      made_ff <= NIL)
      else $error("task count beyond table");

   a_running_created: assert property (@(posedge clock) disable iff (reset)
      (running_ff == NIL) || (running_ff < made_ff))
      else $error("running task not created");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not start sequencer");

   a_rotate_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RW2) |-> (h_cur != NIL))
      else $error("rotation left empty queue head");

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the priority round-robin task scheduler: random and
// directed create, delay, tick and schedule commands are checked against a
// behavioral model of the ready and delay queues kept in a scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NT = prrts_pkg::DEF_NUM_TASKS;
   localparam int NP = prrts_pkg::DEF_NUM_PRIORITIES;
   localparam int DQ = NP;
   localparam int NIL = NT;
   localparam int WATCHDOG_LIMIT = 20000;

   class sched_scoreboard;
      int unsigned        prio [NT];
      bit                 yields [NT];
      int unsigned        dly [NT];
      int unsigned        nxt [NT];
      int unsigned        head [NP+1];
      int unsigned        tail [NP+1];
      int unsigned        running;
      int unsigned        made;
      prrts_pkg::rsp_type pending [$];
      int                 errors;

      function new();
         for (int i = 0; i < NT; i++) begin
            prio[i] = 0; yields[i] = 0; dly[i] = 0; nxt[i] = NIL;
         end
         for (int q = 0; q <= NP; q++) begin
            head[q] = NIL; tail[q] = NIL;
         end
         running = NIL;
         made = 0;
         errors = 0;
      endfunction

      function bit valid_slot(int unsigned t);
         return t < made && t < NT;
      endfunction

      function void append(int unsigned q, int unsigned t);
         nxt[t] = NIL;
         if (!valid_slot(head[q])) head[q] = t;
         else nxt[tail[q]] = t;
         tail[q] = t;
      endfunction

      function void unlink(int unsigned q, int unsigned t);
         int unsigned prv, cur, nx;
         prv = NIL;
         cur = head[q];
         for (int n = 0; n < NT && valid_slot(cur); n++) begin
            nx = nxt[cur];
            if (cur == t) begin
               if (valid_slot(prv)) nxt[prv] = nx;
               else head[q] = nx;
               if (tail[q] == t) tail[q] = prv;
               nxt[t] = NIL;
               return;
            end
            prv = cur;
            cur = nx;
         end
      endfunction

      function bit holds(int unsigned q, int unsigned t);
         int unsigned cur;
         cur = head[q];
         for (int n = 0; n < NT && valid_slot(cur); n++) begin
            if (cur == t) return 1;
            cur = nxt[cur];
         end
         return 0;
      endfunction

      function bit rotate(int unsigned q);
         int unsigned h, nx;
         h = head[q];
         nx = nxt[h];
         if (valid_slot(nx)) begin
            nxt[tail[q]] = h;
            nxt[h] = NIL;
            tail[q] = h;
            head[q] = nx;
         end
         return yields[head[q]];
      endfunction

      function void note_command(prrts_pkg::req_type r);
         prrts_pkg::rsp_type e;
         int unsigned        t, p, cur, nx, woken;
         e = '0;
         case (r.kind)
            prrts_pkg::KIND_CREATE: begin
               if (made < NT) begin
                  t = made;
                  p = r.task_priority;
                  if (p >= NP) p = NP - 1;
                  prio[t] = p;
                  yields[t] = r.yield_flag;
                  dly[t] = 0;
                  made++;
                  append(p, t);
                  e.task_id = t[3:0];
                  e.task_valid = 1'b1;
               end else e.status = prrts_pkg::STATUS_FULL;
            end
            prrts_pkg::KIND_DELAY: begin
               t = running;
               if (valid_slot(t)) begin
                  dly[t] = r.delay_ticks;
                  unlink(prio[t], t);
                  if (!holds(DQ, t)) append(DQ, t);
                  e.task_id = t[3:0];
                  e.task_valid = 1'b1;
               end else e.status = prrts_pkg::STATUS_NO_RUN;
            end
            prrts_pkg::KIND_TICK: begin
               woken = 0;
               cur = head[DQ];
               for (int n = 0; n < NT && valid_slot(cur); n++) begin
                  nx = nxt[cur];
                  if (dly[cur] > 0) dly[cur]--;
                  if (dly[cur] == 0) begin
                     unlink(DQ, cur);
                     append(prio[cur], cur);
                     woken++;
                  end
                  cur = nx;
               end
               e.woken_count = woken[4:0];
            end
            default: begin
               e.status = prrts_pkg::STATUS_NO_READY;
               for (int q = NP - 1; q >= 0; q--) begin
                  if (valid_slot(head[q])) begin
                     if (valid_slot(running) && running == head[q]
                         && valid_slot(nxt[head[q]])) begin
                        for (int n = 0; n <= NT; n++) begin
                           if (!rotate(q)) break;
                           if (head[q] == running) begin
                              void'(rotate(q));
                              break;
                           end
                        end
                     end
                     running = head[q];
                     e.task_id = running[3:0];
                     e.task_valid = 1'b1;
                     e.status = prrts_pkg::STATUS_OK;
                     break;
                  end
               end
            end
         endcase
         pending.push_back(e);
      endfunction

      function void check_result(prrts_pkg::rsp_type a);
         prrts_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result %p", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.task_id !== e.task_id) begin
            $error("task_id exp %0d got %0d", e.task_id, a.task_id); errors++;
         end
         if (a.task_valid !== e.task_valid) begin
            $error("task_valid exp %0d got %0d", e.task_valid, a.task_valid); errors++;
         end
         if (a.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, a.status); errors++;
         end
         if (a.woken_count !== e.woken_count) begin
            $error("woken_count exp %0d got %0d", e.woken_count, a.woken_count);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   prrts_pkg::req_type req_data = '0;
   logic               rsp_valid;
   prrts_pkg::rsp_type rsp_data;

   sched_scoreboard sb = new();
   int unsigned     idle_pct = 0;
   int unsigned     quiet_cycles = 0;

   always #1 clock = ~clock;

   priority_round_robin_task_scheduler i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[priority_round_robin_task_scheduler] ERROR");
         $finish;
      end
   end

   // start stays high from one command to the next unless an idle gap is drawn
   task automatic issue(input logic [1:0] kind, input logic [2:0] p,
                        input logic yf, input logic [31:0] ticks);
      prrts_pkg::req_type r;
      r.kind = kind;
      r.task_priority = p;
      r.yield_flag = yf;
      r.delay_ticks = ticks;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_command(r);
   endtask

   task automatic random_command();
      int unsigned sel;
      logic [31:0] ticks;
      sel = $urandom_range(99);
      case ($urandom_range(3))
         0: ticks = $urandom_range(3);
         1: ticks = $urandom_range(12);
         2: ticks = $urandom();
         default: ticks = 32'hFFFF_FFFF - $urandom_range(1);
      endcase
      if (sel < 12)
         issue(prrts_pkg::KIND_CREATE, 3'($urandom()), 1'($urandom()), $urandom());
      else if (sel < 35)
         issue(prrts_pkg::KIND_DELAY, 3'($urandom()), 1'($urandom()), ticks);
      else if (sel < 65)
         issue(prrts_pkg::KIND_TICK, 3'($urandom()), 1'($urandom()), $urandom());
      else
         issue(prrts_pkg::KIND_SCHEDULE, 3'($urandom()), 1'($urandom()), $urandom());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty scheduler corner cases
      issue(prrts_pkg::KIND_DELAY, 3'd0, 1'b0, 32'd5);
      issue(prrts_pkg::KIND_SCHEDULE, 3'd7, 1'b1, 32'hFFFF_FFFF);
      issue(prrts_pkg::KIND_TICK, 3'd0, 1'b0, 32'd0);
      // peers at the top priority with yields, low and mid tasks
      issue(prrts_pkg::KIND_CREATE, 3'd7, 1'b0, 32'hFFFF_FFFF);
      issue(prrts_pkg::KIND_CREATE, 3'd7, 1'b1, 32'd0);
      issue(prrts_pkg::KIND_CREATE, 3'd7, 1'b1, 32'd0);
      issue(prrts_pkg::KIND_CREATE, 3'd0, 1'b0, 32'd0);
      issue(prrts_pkg::KIND_CREATE, 3'd5, 1'b1, 32'd0);
      issue(prrts_pkg::KIND_SCHEDULE, 3'd0, 1'b0, 32'd0);
      issue(prrts_pkg::KIND_SCHEDULE, 3'd0, 1'b0, 32'd0);
      issue(prrts_pkg::KIND_SCHEDULE, 3'd0, 1'b0, 32'd0);
      issue(prrts_pkg::KIND_DELAY, 3'd0, 1'b0, 32'd0);
      issue(prrts_pkg::KIND_DELAY, 3'd0, 1'b0, 32'd2);
      issue(prrts_pkg::KIND_SCHEDULE, 3'd0, 1'b0, 32'd0);
      issue(prrts_pkg::KIND_DELAY, 3'd0, 1'b0, 32'hFFFF_FFFF);
      issue(prrts_pkg::KIND_TICK, 3'd0, 1'b0, 32'd0);
      issue(prrts_pkg::KIND_TICK, 3'd0, 1'b0, 32'd0);
      issue(prrts_pkg::KIND_SCHEDULE, 3'd0, 1'b0, 32'd0);

      for (int i = 0; i < 450; i++) begin
         case ((i * 4) / 450)
            0: idle_pct = 0;
            1: idle_pct = 76;
            2: idle_pct = 15;
            default: idle_pct = (i % 40 < 20) ? 0 : 76;
         endcase
         random_command();
         // fill the table partway through to reach the full case
         if (i == 300) begin
            for (int k = 0; k < NT; k++)
               issue(prrts_pkg::KIND_CREATE, 3'($urandom()), 1'($urandom()), 32'd0);
         end
      end
      start <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("[priority_round_robin_task_scheduler] OK");
      else
         $display("[priority_round_robin_task_scheduler] ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/prrts_pkg.sv
rtl/core/prrts_ram.sv
rtl/core/priority_round_robin_task_scheduler.sv
dv/tb_top.sv
